// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the ray/box slab test RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RBST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBST_ASSERT(lbl, clk, rst_n, prop)
`define RBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rbst_pkg.sv -----
// Shared types, constants and helpers for the ray/box slab test.
// No dependencies.
package rbst_pkg;

    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = Q_W + 1;
    localparam int NUM_W      = DIFF_W + FRAC_W;
    localparam int DIV_STAGES = Q_W;
    localparam int AXES       = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic dzero;
        logic in_slab;
        logic below;
        logic neg_lo;
        logic neg_hi;
    } t_axis_flags;

    typedef struct packed {
        logic [DIFF_W-1:0] mag_lo;
        logic [DIFF_W-1:0] mag_hi;
        logic [Q_W-1:0]    mag_den;
        t_axis_flags       flags;
    } t_axis_work;

    typedef t_axis_work  [AXES-1:0] t_work;
    typedef t_axis_flags [AXES-1:0] t_flags;
    typedef logic signed [AXES-1:0][Q_W-1:0] t_vec;

    // signed, saturated quotient from magnitude, overflow flag and sign
    function automatic logic signed [Q_W-1:0] sat_quot(input logic [Q_W-1:0] q,
                                                       input logic ovf,
                                                       input logic neg);
        logic signed [Q_W-1:0] res;
        if (!neg) begin
            res = (ovf || q[Q_W-1]) ? Q_MAX : $signed(q);
        end else begin
            res = (ovf || (q[Q_W-1] && (|q[Q_W-2:0]))) ? Q_MIN : -$signed(q);
        end
        return res;
    endfunction

endpackage

// ----- rtl/rbst_front.sv -----
// Front end: takes a ray request, forms slab differences and classifies axes.
// Depends on rbst_pkg.
module rbst_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  rbst_pkg::t_vec      i_origin,
    input  rbst_pkg::t_vec      i_dir,
    input  rbst_pkg::t_vec      i_box_min,
    input  rbst_pkg::t_vec      i_box_max,
    input  logic                i_q_full,
    output logic                o_q_push,
    output rbst_pkg::t_work     o_work
);

    logic            r_vld;
    rbst_pkg::t_work r_work;
    rbst_pkg::t_work n_work;
    logic            accept;

    always_comb begin
        logic signed [rbst_pkg::DIFF_W-1:0] dlo [rbst_pkg::AXES];
        logic signed [rbst_pkg::DIFF_W-1:0] dhi [rbst_pkg::AXES];
        for (int a = 0; a < rbst_pkg::AXES; a++) begin
            dlo[a] = $signed({i_box_min[a][rbst_pkg::Q_W-1], i_box_min[a]})
                   - $signed({i_origin[a][rbst_pkg::Q_W-1], i_origin[a]});
            dhi[a] = $signed({i_box_max[a][rbst_pkg::Q_W-1], i_box_max[a]})
                   - $signed({i_origin[a][rbst_pkg::Q_W-1], i_origin[a]});
            n_work[a].mag_lo  = dlo[a][rbst_pkg::DIFF_W-1] ? -dlo[a] : dlo[a];
            n_work[a].mag_hi  = dhi[a][rbst_pkg::DIFF_W-1] ? -dhi[a] : dhi[a];
            n_work[a].mag_den = i_dir[a][rbst_pkg::Q_W-1] ? -i_dir[a] : i_dir[a];
            n_work[a].flags.dzero   = (i_dir[a] == '0);
            n_work[a].flags.in_slab = ($signed(i_box_min[a]) <= $signed(i_origin[a]))
                                    && ($signed(i_origin[a]) <= $signed(i_box_max[a]));
            n_work[a].flags.below   = ($signed(i_origin[a]) < $signed(i_box_min[a]));
            n_work[a].flags.neg_lo = dlo[a][rbst_pkg::DIFF_W-1] ^ i_dir[a][rbst_pkg::Q_W-1];
            n_work[a].flags.neg_hi = dhi[a][rbst_pkg::DIFF_W-1] ^ i_dir[a][rbst_pkg::Q_W-1];
        end
    end

    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_work   = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

// ----- rtl/rbst_fifo.sv -----
// Short request queue between front and back end.
// Depends on rbst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rbst_fifo #(
    parameter int DEPTH = rbst_pkg::FIFO_DEPTH  // 2 or more
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rbst_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output rbst_pkg::t_work o_data,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbst_pkg::t_work  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `RBST_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH))
    `RBST_ASSERT(a_no_overrun, i_clk, i_rst_n, !(i_push && o_full))
    `RBST_ASSERT(a_no_underrun, i_clk, i_rst_n, !(i_pop && o_empty))

endmodule

// ----- rtl/rbst_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage, overflow check first.
// Depends on rbst_pkg.
module rbst_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rbst_pkg::NUM_W-1:0]    i_num,
    input  logic [rbst_pkg::Q_W-1:0]      i_den,
    output logic [rbst_pkg::Q_W-1:0]      o_quot,
    output logic                          o_ovf
);

    localparam int W  = rbst_pkg::Q_W;
    localparam int N  = rbst_pkg::DIV_STAGES;
    localparam int HW = rbst_pkg::NUM_W - W;

    logic [W-1:0] r_rem [N+1];
    logic [W-1:0] r_low [N+1];
    logic [W-1:0] r_den [N+1];
    logic [W-1:0] r_q   [N+1];
    logic         r_ovf [N+1];

    // quotient of 2^32 or more saturates whatever the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(i_num[rbst_pkg::NUM_W-1:W]);
            r_low[0] <= i_num[W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (W'(i_num[rbst_pkg::NUM_W-1:W]) >= i_den);
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic [W:0] trial;
        logic       ge;
        logic [W:0] diff;
        assign trial = {r_rem[k-1], r_low[k-1][W-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});
        assign diff  = trial - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
                r_low[k] <= {r_low[k-1][W-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][W-2:0], ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_q[N];
    assign o_ovf  = r_ovf[N];

endmodule

// ----- rtl/rbst_back.sv -----
// Back end: six slab dividers, per-axis sort, entry/exit reduction, result register.
// Depends on rbst_pkg, rbst_div and assert_macros.svh.
`include "assert_macros.svh"
module rbst_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  rbst_pkg::t_work               i_work,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_hit,
    output logic signed [rbst_pkg::Q_W-1:0] o_entry,
    output logic signed [rbst_pkg::Q_W-1:0] o_exit
);

    localparam int W = rbst_pkg::Q_W;
    localparam int N = rbst_pkg::DIV_STAGES;
    localparam int A = rbst_pkg::AXES;

    logic             adv;
    logic             r_vld  [N+1];
    rbst_pkg::t_flags r_flag [N+1];

    logic [W-1:0] quot_lo [A];
    logic [W-1:0] quot_hi [A];
    logic         ovf_lo  [A];
    logic         ovf_hi  [A];

    logic         r_avld;
    logic         r_amiss;
    rbst_pkg::t_vec r_near;
    rbst_pkg::t_vec r_far;
    rbst_pkg::t_vec n_near;
    rbst_pkg::t_vec n_far;
    logic         n_amiss;

    logic                r_ovld;
    logic                r_hit;
    logic signed [W-1:0] r_entry;
    logic signed [W-1:0] r_exit;
    logic signed [W-1:0] n_entry;
    logic signed [W-1:0] n_exit;
    logic                n_hit;

    // whole pipeline moves while the result register can take a new request
    assign adv     = !r_ovld || i_pop;
    assign o_q_pop = adv && !i_q_empty;

    for (genvar a = 0; a < A; a++) begin : g_axis
        rbst_div u_div_lo (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  ({i_work[a].mag_lo, {rbst_pkg::FRAC_W{1'b0}}}),
            .i_den  (i_work[a].mag_den),
            .o_quot (quot_lo[a]),
            .o_ovf  (ovf_lo[a])
        );
        rbst_div u_div_hi (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  ({i_work[a].mag_hi, {rbst_pkg::FRAC_W{1'b0}}}),
            .i_den  (i_work[a].mag_den),
            .o_quot (quot_hi[a]),
            .o_ovf  (ovf_hi[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_avld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= !i_q_empty;
            for (int k = 1; k <= N; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_avld <= r_vld[N];
            r_ovld <= r_avld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < A; a++) begin
                r_flag[0][a] <= i_work[a].flags;
            end
            for (int k = 1; k <= N; k++) begin
                r_flag[k] <= r_flag[k-1];
            end
        end
    end

    // per-axis saturation and sort; zero direction bypasses the divider result
    always_comb begin
        logic signed [W-1:0] ta;
        logic signed [W-1:0] tb;
        n_amiss = 1'b0;
        for (int a = 0; a < A; a++) begin
            ta = rbst_pkg::sat_quot(quot_lo[a], ovf_lo[a], r_flag[N][a].neg_lo);
            tb = rbst_pkg::sat_quot(quot_hi[a], ovf_hi[a], r_flag[N][a].neg_hi);
            if (r_flag[N][a].dzero) begin
                if (r_flag[N][a].in_slab) begin
                    n_near[a] = rbst_pkg::Q_MIN;
                    n_far[a]  = rbst_pkg::Q_MAX;
                end else if (r_flag[N][a].below) begin
                    n_near[a] = rbst_pkg::Q_MAX;
                    n_far[a]  = rbst_pkg::Q_MAX;
                    n_amiss   = 1'b1;
                end else begin
                    n_near[a] = rbst_pkg::Q_MIN;
                    n_far[a]  = rbst_pkg::Q_MIN;
                    n_amiss   = 1'b1;
                end
            end else begin
                n_near[a] = (ta < tb) ? ta : tb;
                n_far[a]  = (ta < tb) ? tb : ta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_near  <= n_near;
            r_far   <= n_far;
            r_amiss <= n_amiss;
        end
    end

    // element selects of the packed vector are unsigned, so compare as signed
    always_comb begin
        n_entry = $signed(r_near[0]);
        n_exit  = $signed(r_far[0]);
        for (int a = 1; a < A; a++) begin
            if ($signed(r_near[a]) > n_entry) begin
                n_entry = $signed(r_near[a]);
            end
            if ($signed(r_far[a]) < n_exit) begin
                n_exit = $signed(r_far[a]);
            end
        end
        n_hit = !r_amiss && (n_entry < n_exit) && (n_exit > $signed(W'(0)));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit   <= n_hit;
            r_entry <= n_entry;
            r_exit  <= n_exit;
        end
    end

    assign o_empty = !r_ovld;
    assign o_hit   = r_hit;
    assign o_entry = r_entry;
    assign o_exit  = r_exit;

    `RBST_ASSERT(a_hit_order, i_clk, i_rst_n, !(r_ovld && r_hit) || (r_entry < r_exit))
    `RBST_ASSERT(a_hit_ahead, i_clk, i_rst_n, !(r_ovld && r_hit) || (r_exit > $signed(W'(0))))
    `RBST_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_ovld && !i_pop, r_ovld && $stable(r_exit))

endmodule

// ----- rtl/ray_box_slab_test_unit.sv -----
// Ray against axis-aligned box slab test, top level.
// Depends on rbst_pkg, rbst_front, rbst_fifo, rbst_div and rbst_back.
//
// Usage:
//   Box bounds live in six registers written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata (0..2 box min x/y/z, 3..5 box max x/y/z, others ignored).
//   Write them only while no ray is in flight.
//   Rays enter on a queue-style channel: push with full; a request is taken
//   at a clock edge with push high and full low.
//   Results leave the same way: the oldest result sits on o_hit,
//   o_entry_distance and o_exit_distance while empty is low, and pop
//   takes it.
//   A request passes the front register, the request queue, the 33-stage
//   divider pipeline (overflow check plus one quotient bit per stage; six
//   dividers side by side), the sort register and the result register.
//   Throughput is one ray per cycle while pop keeps up.
//   When pop stays low the back end holds, the request queue fills, and
//   full rises once the front register is also occupied.
//   Synchronous active-low reset empties every stage and clears the box to 0.
module ray_box_slab_test_unit #(
    parameter int FIFO_DEPTH = rbst_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbst_pkg::Q_W-1:0]          i_cfg_wdata,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_origin_x,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_origin_y,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_origin_z,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_direction_x,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_direction_y,
    input  logic signed [rbst_pkg::Q_W-1:0]   i_direction_z,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_hit,
    output logic signed [rbst_pkg::Q_W-1:0]   o_entry_distance,
    output logic signed [rbst_pkg::Q_W-1:0]   o_exit_distance
);

    rbst_pkg::t_vec  r_box_min;
    rbst_pkg::t_vec  r_box_max;
    rbst_pkg::t_vec  origin;
    rbst_pkg::t_vec  dir;
    rbst_pkg::t_work front_work;
    rbst_pkg::t_work q_work;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= '0;
            r_box_max <= '0;
        end else if (i_cfg_we) begin
            unique case (rbst_pkg::t_reg_idx'(i_cfg_idx))
                rbst_pkg::REG_BOX_MIN_X: r_box_min[0] <= i_cfg_wdata;
                rbst_pkg::REG_BOX_MIN_Y: r_box_min[1] <= i_cfg_wdata;
                rbst_pkg::REG_BOX_MIN_Z: r_box_min[2] <= i_cfg_wdata;
                rbst_pkg::REG_BOX_MAX_X: r_box_max[0] <= i_cfg_wdata;
                rbst_pkg::REG_BOX_MAX_Y: r_box_max[1] <= i_cfg_wdata;
                rbst_pkg::REG_BOX_MAX_Z: r_box_max[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign origin = {i_origin_z, i_origin_y, i_origin_x};
    assign dir    = {i_direction_z, i_direction_y, i_direction_x};

    rbst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_origin  (origin),
        .i_dir     (dir),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_work    (front_work)
    );

    rbst_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_work),
        .o_empty (q_empty)
    );

    rbst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_work    (q_work),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_hit     (o_hit),
        .o_entry   (o_entry_distance),
        .o_exit    (o_exit_distance)
    );

endmodule
